FILE: rtl/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

    localparam logic [6:0] LEN_CODE_EXT16   = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES      = 4'd2;
    localparam logic [3:0] EXT64_BYTES      = 4'd8;
    localparam logic [3:0] KEY_BYTES        = 4'd4;
    localparam logic [63:0] CTRL_MAX_LEN    = 64'd125;
    localparam logic [3:0] OPC_RSVD_LO_MIN  = 4'd3;
    localparam logic [3:0] OPC_RSVD_LO_MAX  = 4'd7;
    localparam logic [3:0] OPC_RSVD_HI_MIN  = 4'd11;

    typedef struct packed {
        logic        result_kind;
        logic        fin_flag;
        logic [2:0]  reserved_bits;
        logic [3:0]  frame_opcode;
        logic        mask_present;
        logic [63:0] payload_length;
        logic        header_valid;
        logic [7:0]  payload_byte;
        logic        frame_end;
    } wsd_result_t;

    // reserved opcodes, or a control frame longer than allowed
    function automatic logic hdr_ok(input logic [3:0] op, input logic [63:0] len);
        logic reserved;
        logic ctrl_long;
        reserved  = ((op >= OPC_RSVD_LO_MIN) && (op <= OPC_RSVD_LO_MAX))
                  || (op >= OPC_RSVD_HI_MIN);
        ctrl_long = op[3] && (len > CTRL_MAX_LEN);
        return !(reserved || ctrl_long);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/wsd_in_if.sv
`default_nettype none

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/wsd_res_if.sv
`default_nettype none

interface wsd_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        fin_flag;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [63:0] payload_length;
    logic        header_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;

    modport source (
        output valid, output result_kind, output fin_flag, output reserved_bits,
        output frame_opcode, output mask_present, output payload_length,
        output header_valid, output payload_byte, output frame_end,
        input ready
    );
    modport sink (
        input valid, input result_kind, input fin_flag, input reserved_bits,
        input frame_opcode, input mask_present, input payload_length,
        input header_valid, input payload_byte, input frame_end,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/wsd_parser.sv
`default_nettype none

module wsd_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          in_byte,
    output logic                     res_valid,
    output wsd_pkg::wsd_result_t     res_data
);
    import wsd_pkg::*;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [8:0]  hdr_reg, hdr_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] rem_reg, rem_next;
    logic [1:0]  kidx_reg, kidx_next;

    logic        after_len;
    logic        finish;
    logic        emit;
    logic        kind;
    logic        fend;
    logic [7:0]  pbyte;
    logic [7:0]  key_byte;
    logic [6:0]  code;

    assign code = in_byte[6:0];

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        len_next   = len_reg;
        key_next   = key_reg;
        rem_next   = rem_reg;
        kidx_next  = kidx_reg;
        after_len  = 1'b0;
        finish     = 1'b0;
        emit       = 1'b0;
        kind       = 1'b0;
        fend       = 1'b0;
        pbyte      = 8'd0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    hdr_next   = {in_byte, 1'b0};
                    len_next   = 64'd0;
                    key_next   = 32'd0;
                    phase_next = PH_SECOND;
                end
                PH_SECOND:
                begin
                    hdr_next = {hdr_reg[8:1], in_byte[7]};
                    if ((code == LEN_CODE_EXT16) || (code == LEN_CODE_EXT64))
                    begin
                        len_next   = 64'd0;
                        cnt_next   = (code == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        len_next  = {57'd0, code};
                        after_len = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    len_next = {len_reg[55:0], in_byte};
                    if (cnt_reg != 4'd0)
                        cnt_next = cnt_reg - 4'd1;
                    if (cnt_next == 4'd0)
                        after_len = 1'b1;
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    if (cnt_reg != 4'd0)
                        cnt_next = cnt_reg - 4'd1;
                    if (cnt_next == 4'd0)
                        finish = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    if (rem_reg != 64'd0)
                        rem_next = rem_reg - 64'd1;
                    kidx_next = kidx_reg + 2'd1;
                    emit      = 1'b1;
                    kind      = 1'b1;
                    pbyte     = in_byte ^ key_byte;
                    fend      = (rem_next == 64'd0);
                    if (fend)
                        phase_next = PH_FIRST;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase

            // length known: either collect the mask key or close the header
            if (after_len)
            begin
                if (hdr_next[0])
                begin
                    phase_next = PH_KEY;
                    cnt_next   = KEY_BYTES;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            if (finish)
            begin
                rem_next   = len_next;
                kidx_next  = 2'd0;
                cnt_next   = 4'd0;
                emit       = 1'b1;
                fend       = (len_next == 64'd0);
                phase_next = fend ? PH_FIRST : PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            cnt_reg   <= 4'd0;
            hdr_reg   <= 9'd0;
            len_reg   <= 64'd0;
            key_reg   <= 32'd0;
            rem_reg   <= 64'd0;
            kidx_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            hdr_reg   <= hdr_next;
            len_reg   <= len_next;
            key_reg   <= key_next;
            rem_reg   <= rem_next;
            kidx_reg  <= kidx_next;
        end
    end

    assign res_valid               = emit;
    assign res_data.result_kind    = kind;
    assign res_data.fin_flag       = hdr_next[8];
    assign res_data.reserved_bits  = hdr_next[7:5];
    assign res_data.frame_opcode   = hdr_next[4:1];
    assign res_data.mask_present   = hdr_next[0];
    assign res_data.payload_length = len_next;
    assign res_data.header_valid   = hdr_ok(hdr_next[4:1], len_next);
    assign res_data.payload_byte   = pbyte;
    assign res_data.frame_end      = fend;

endmodule

`default_nettype wire

FILE: rtl/wsd_res_buf.sv
`default_nettype none

module wsd_res_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wsd_pkg::wsd_result_t      push_data,
    input  wire logic                 pop_ready,
    output logic                      out_valid,
    output wsd_pkg::wsd_result_t      out_data,
    output logic                      full
);
    import wsd_pkg::*;

    wsd_result_t slot0_reg, slot1_reg;
    logic [1:0]  count_reg;
    logic        pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign full      = (count_reg == 2'd2);
    assign pop       = out_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // head slot always holds the oldest beat
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
                slot0_reg <= slot1_reg;
            else if (push)
                slot0_reg <= push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                slot0_reg <= push_data;
            else
                slot1_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/websocket_frame_deframer.sv
// a result beat is registered in the result buffer and offered behind any older beat
// throughput: one byte per cycle while ready; header bytes but the last give no beat
// a two-beat result buffer keeps input ready while one beat waits downstream
// input ready drops only when both buffer slots are occupied
// reset is asynchronous: parser returns to the first header byte, buffer empties
`default_nettype none

module websocket_frame_deframer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wsd_in_if.sink      stream,
    wsd_res_if.source   result
);
    import wsd_pkg::*;

    logic        accept;
    logic        par_valid;
    wsd_result_t par_data;
    logic        buf_valid;
    wsd_result_t buf_data;
    logic        buf_full;

    assign stream.ready = !buf_full;
    assign accept       = stream.valid && stream.ready;

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (stream.in_byte),
        .res_valid (par_valid),
        .res_data  (par_data)
    );

    wsd_res_buf u_res_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (par_valid),
        .push_data (par_data),
        .pop_ready (result.ready),
        .out_valid (buf_valid),
        .out_data  (buf_data),
        .full      (buf_full)
    );

    assign result.valid          = buf_valid;
    assign result.result_kind    = buf_data.result_kind;
    assign result.fin_flag       = buf_data.fin_flag;
    assign result.reserved_bits  = buf_data.reserved_bits;
    assign result.frame_opcode   = buf_data.frame_opcode;
    assign result.mask_present   = buf_data.mask_present;
    assign result.payload_length = buf_data.payload_length;
    assign result.header_valid   = buf_data.header_valid;
    assign result.payload_byte   = buf_data.payload_byte;
    assign result.frame_end      = buf_data.frame_end;

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        par_valid |-> !buf_full)
        else $error("result pushed into full buffer");

    a_header_end_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.result_kind)
            |-> (result.frame_end == (result.payload_length == 64'd0)))
        else $error("header frame_end disagrees with payload length");

    a_header_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.result_kind) |-> (result.payload_byte == 8'd0))
        else $error("header beat carries a payload byte");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_full && !result.ready) |=> buf_full)
        else $error("buffer lost a beat while stalled");
`endif

endmodule

`default_nettype wire
